[sv/htd_pkg.sv]
// ----------------------------------------------------------------------------
// htd_pkg
// Shared types and constants for the Huffman tree header decoder.
// ----------------------------------------------------------------------------
package htd_pkg;

  localparam int MAX_LEAVES  = 256;
  localparam int SYMBOL_BITS = 8;
  localparam int MAX_NODES   = 2 * MAX_LEAVES - 1;

  localparam int STACK_AW = $clog2(MAX_LEAVES);
  localparam int DEPTH_W  = $clog2(MAX_LEAVES + 1);
  localparam int NODE_W   = $clog2(MAX_NODES + 1);
  localparam int SYM_W    = SYMBOL_BITS;
  localparam int SLEFT_W  = $clog2(SYMBOL_BITS + 1);

  // header formats
  localparam logic FMT_PACKED = 1'b0;
  localparam logic FMT_TEXT   = 1'b1;

  // text format command bytes
  localparam logic [7:0] TEXT_LEAF = 8'h31;
  localparam logic [7:0] TEXT_NUL  = 8'h00;

  // step unit actions
  localparam logic [2:0] ACT_NONE   = 3'd0;  // symbol bookkeeping only
  localparam logic [2:0] ACT_LEAF   = 3'd1;  // push a leaf
  localparam logic [2:0] ACT_BRANCH = 3'd2;  // pop two, push branch (needs stack read)
  localparam logic [2:0] ACT_DONE   = 3'd3;  // single entry left: root found
  localparam logic [2:0] ACT_FAIL   = 3'd4;  // malformed header
  localparam logic [2:0] ACT_STOP   = 3'd5;  // decoder already done or failed

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [NODE_W-1:0]  next_node;
    logic [SLEFT_W-1:0] sym_left;
    logic [SYM_W-1:0]   sym_shift;
    logic               finished;
    logic               failed;
  } ctx_t;

  typedef struct packed {
    logic [2:0]         act;
    logic [SLEFT_W-1:0] sym_left;
    logic [SYM_W-1:0]   sym_shift;
    logic [SYM_W-1:0]   leaf_sym;
  } step_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic              is_leaf;
    logic [SYM_W-1:0]  symbol;
    logic [NODE_W-1:0] left_child;
    logic [NODE_W-1:0] right_child;
    logic              tree_done;
    logic              error_flag;
    logic              last_of_byte;
  } rec_t;

endpackage

[sv/htd_stack_ram.sv]
// ----------------------------------------------------------------------------
// htd_stack_ram
// Node index stack storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module htd_stack_ram
  import htd_pkg::*;
(
  input  logic                clk,
  input  logic                wr_en,
  input  logic [STACK_AW-1:0] wr_addr,
  input  logic [NODE_W-1:0]   wr_data,
  input  logic                rd_en,
  input  logic [STACK_AW-1:0] rd_addr,
  output logic [NODE_W-1:0]   rd_data
);

  logic [NODE_W-1:0] mem [MAX_LEAVES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/htd_step_unit.sv]
// ----------------------------------------------------------------------------
// htd_step_unit
// Decodes one header command (one bit, or one text byte) against the
// current stack and symbol state.
// ----------------------------------------------------------------------------
module htd_step_unit
  import htd_pkg::*;
(
  input  logic       fmt,
  input  logic [7:0] hdr_byte,
  input  logic [2:0] bit_pos,
  input  ctx_t       ctx,
  output step_t      step
);

  logic             cur_bit;
  logic [SYM_W-1:0] shifted;
  logic             want_leaf;
  logic             want_branch;

  assign cur_bit = hdr_byte[bit_pos];
  assign shifted = {ctx.sym_shift[SYM_W-2:0], cur_bit};

  always_comb begin
    step          = '0;
    step.act      = ACT_NONE;
    step.sym_left = ctx.sym_left;
    step.sym_shift = ctx.sym_shift;
    step.leaf_sym = '0;
    want_leaf     = 1'b0;
    want_branch   = 1'b0;

    if (ctx.finished || ctx.failed) begin
      step.act = ACT_STOP;
    end else if (fmt == FMT_TEXT) begin
      if (ctx.sym_left != '0) begin
        step.sym_left  = '0;
        step.sym_shift = '0;
        step.leaf_sym  = hdr_byte;
        want_leaf      = 1'b1;
      end else if (hdr_byte == TEXT_LEAF) begin
        step.sym_left  = SLEFT_W'(SYMBOL_BITS);
        step.sym_shift = '0;
      end else if (hdr_byte == TEXT_NUL) begin
        step.act = ACT_FAIL;
      end else begin
        want_branch = 1'b1;
      end
    end else begin
      if (ctx.sym_left != '0) begin
        step.sym_shift = shifted;
        step.sym_left  = ctx.sym_left - SLEFT_W'(1);
        if (ctx.sym_left == SLEFT_W'(1)) begin
          step.leaf_sym = shifted;
          want_leaf     = 1'b1;
        end
      end else if (cur_bit) begin
        step.sym_left  = SLEFT_W'(SYMBOL_BITS);
        step.sym_shift = '0;
      end else begin
        want_branch = 1'b1;
      end
    end

    if (want_leaf) begin
      if (ctx.depth >= DEPTH_W'(MAX_LEAVES) || ctx.next_node >= NODE_W'(MAX_NODES)) begin
        step.act = ACT_FAIL;
      end else begin
        step.act = ACT_LEAF;
      end
    end

    if (want_branch) begin
      priority if (ctx.depth == '0) begin
        step.act = ACT_FAIL;
      end else if (ctx.depth == DEPTH_W'(1)) begin
        step.act = ACT_DONE;
      end else if (ctx.next_node >= NODE_W'(MAX_NODES)) begin
        step.act = ACT_FAIL;
      end else begin
        step.act = ACT_BRANCH;
      end
    end
  end

endmodule

[sv/huffman_tree_header_decoder.sv]
// ----------------------------------------------------------------------------
// huffman_tree_header_decoder
// Rebuilds a post-order Huffman tree from its serialized header and emits
// one node record for each node created, plus one record on completion or error.
// ----------------------------------------------------------------------------
// Sequence: a byte is accepted in S_IDLE, each header bit is decoded in S_BIT,
//   a branch bit also passes through S_READ (stack RAM read), and S_FLUSH ends
//   the byte; once the decoder is done or failed, the remaining bits are skipped.
//   A text byte is one command. Output stalls can hold S_BIT, S_READ and S_FLUSH.
// Throughput: one byte at a time; in_stall stays high until the byte's last
//   record sits in the output register.
// Reset: rst (sync) clears control, counters, flags and header_format. The
//   stack RAM is not cleared; only entries below the depth are ever read.
// ----------------------------------------------------------------------------
module huffman_tree_header_decoder
  import htd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_we,
  input  logic              cfg_data,
  // input request
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        header_byte,
  input  logic              first_byte,
  // output request
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NODE_W-1:0] node_index,
  output logic              is_leaf,
  output logic [SYM_W-1:0]  symbol,
  output logic [NODE_W-1:0] left_child,
  output logic [NODE_W-1:0] right_child,
  output logic              tree_done,
  output logic              error_flag,
  output logic              last_of_byte
);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;  // ready for a byte
  localparam logic [1:0] S_BIT   = 2'd1;  // one command per cycle, held while a record has no free slot
  localparam logic [1:0] S_READ  = 2'd2;  // branch: left child arrives from RAM
  localparam logic [1:0] S_FLUSH = 2'd3;  // hand over held record marked last

  logic [1:0]         state, state_next;
  logic               header_format;
  logic [7:0]         byte_q, byte_q_next;
  logic [2:0]         bit_pos, bit_pos_next;
  logic [DEPTH_W-1:0] depth, depth_next;
  logic [NODE_W-1:0]  next_node, next_node_next;
  logic [SLEFT_W-1:0] sym_left, sym_left_next;
  logic [SYM_W-1:0]   sym_shift, sym_shift_next;
  logic               finished, finished_next;
  logic               failed, failed_next;
  logic [NODE_W-1:0]  tos, tos_next;        // copy of the stack top entry

  // one record is held back so the byte's final record can be marked
  logic               pend_valid, pend_valid_next;
  rec_t               pend, pend_next;
  logic               out_valid_next;
  rec_t               out_rec, out_rec_next;

  ctx_t               ctx;
  step_t              step;

  logic                ram_wr_en;
  logic [STACK_AW-1:0] ram_wr_addr;
  logic [NODE_W-1:0]   ram_wr_data;
  logic                ram_rd_en;
  logic [STACK_AW-1:0] below_addr;
  logic [NODE_W-1:0]   ram_rd_data;

  logic               out_free;
  logic               slot_ok;
  logic               emit;
  logic               emit_req;
  logic               advance;
  rec_t               new_rec;
  logic               out_load;
  rec_t               load_rec;
  logic [DEPTH_W-1:0] depth_less2;

  // field order follows ctx_t
  assign ctx = {depth, next_node, sym_left, sym_shift, finished, failed};

  htd_step_unit u_step (
    .fmt      (header_format),
    .hdr_byte (byte_q),
    .bit_pos  (bit_pos),
    .ctx      (ctx),
    .step     (step)
  );

  htd_stack_ram u_stack (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (below_addr),
    .rd_data (ram_rd_data)
  );

  // entry just below the top; only used when depth >= 2
  assign depth_less2 = depth - DEPTH_W'(2);
  assign below_addr  = depth_less2[STACK_AW-1:0];

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign slot_ok  = !pend_valid || out_free;

  always_comb begin
    state_next      = state;
    byte_q_next     = byte_q;
    bit_pos_next    = bit_pos;
    depth_next      = depth;
    next_node_next  = next_node;
    sym_left_next   = sym_left;
    sym_shift_next  = sym_shift;
    finished_next   = finished;
    failed_next     = failed;
    tos_next        = tos;
    pend_valid_next = pend_valid;
    pend_next       = pend;

    ram_wr_en   = 1'b0;
    ram_wr_addr = depth[STACK_AW-1:0];
    ram_wr_data = next_node;
    ram_rd_en   = 1'b0;

    emit     = 1'b0;
    emit_req = 1'b0;
    advance  = 1'b0;
    new_rec  = '0;
    out_load = 1'b0;
    load_rec = pend;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          byte_q_next  = header_byte;
          bit_pos_next = 3'd7;
          state_next   = S_BIT;
          if (first_byte) begin
            depth_next     = '0;
            next_node_next = '0;
            sym_left_next  = '0;
            sym_shift_next = '0;
            finished_next  = 1'b0;
            failed_next    = 1'b0;
          end
        end
      end

      S_BIT: begin
        emit_req = (step.act == ACT_LEAF) || (step.act == ACT_DONE) ||
                   (step.act == ACT_FAIL);
        if (!emit_req || slot_ok) begin
          sym_left_next  = step.sym_left;
          sym_shift_next = step.sym_shift;
          unique case (step.act)
            ACT_STOP: begin
              state_next = S_FLUSH;
            end
            ACT_NONE: begin
              advance = 1'b1;
            end
            ACT_LEAF: begin
              ram_wr_en          = 1'b1;
              tos_next           = next_node;
              depth_next         = depth + DEPTH_W'(1);
              next_node_next     = next_node + NODE_W'(1);
              emit               = 1'b1;
              new_rec.node_index = next_node;
              new_rec.is_leaf    = 1'b1;
              new_rec.symbol     = step.leaf_sym;
              advance            = 1'b1;
            end
            ACT_BRANCH: begin
              ram_rd_en  = 1'b1;
              state_next = S_READ;
            end
            ACT_DONE: begin
              finished_next      = 1'b1;
              emit               = 1'b1;
              new_rec.node_index = tos;
              new_rec.tree_done  = 1'b1;
              advance            = 1'b1;
            end
            ACT_FAIL: begin
              failed_next        = 1'b1;
              emit               = 1'b1;
              new_rec.error_flag = 1'b1;
              advance            = 1'b1;
            end
            default: begin
              advance = 1'b1;
            end
          endcase
        end
      end

      S_READ: begin
        if (slot_ok) begin
          // left child is in ram_rd_data, right child is the cached top
          ram_wr_en           = 1'b1;
          ram_wr_addr         = below_addr;
          tos_next            = next_node;
          depth_next          = depth - DEPTH_W'(1);
          next_node_next      = next_node + NODE_W'(1);
          emit                = 1'b1;
          new_rec.node_index  = next_node;
          new_rec.left_child  = ram_rd_data;
          new_rec.right_child = tos;
          advance             = 1'b1;
        end
      end

      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          out_load              = 1'b1;
          load_rec              = pend;
          load_rec.last_of_byte = 1'b1;
          pend_valid_next       = 1'b0;
          state_next            = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // step to the next header bit, or finish the byte
    if (advance) begin
      if (header_format == FMT_TEXT || bit_pos == 3'd0) begin
        state_next = S_FLUSH;
      end else begin
        bit_pos_next = bit_pos - 3'd1;
        state_next   = S_BIT;
      end
    end

    // a new record pushes the held one out
    if (emit) begin
      pend_next       = new_rec;
      pend_valid_next = 1'b1;
      if (pend_valid) begin
        out_load = 1'b1;
        load_rec = pend;
      end
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    out_rec_next   = out_rec;
    if (out_load) begin
      out_valid_next = 1'b1;
      out_rec_next   = load_rec;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      header_format <= FMT_PACKED;
      bit_pos       <= '0;
      depth         <= '0;
      next_node     <= '0;
      sym_left      <= '0;
      sym_shift     <= '0;
      finished      <= 1'b0;
      failed        <= 1'b0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state      <= state_next;
      bit_pos    <= bit_pos_next;
      depth      <= depth_next;
      next_node  <= next_node_next;
      sym_left   <= sym_left_next;
      sym_shift  <= sym_shift_next;
      finished   <= finished_next;
      failed     <= failed_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
      if (cfg_we) begin
        header_format <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    byte_q  <= byte_q_next;
    tos     <= tos_next;
    pend    <= pend_next;
    out_rec <= out_rec_next;
  end

  assign node_index   = out_rec.node_index;
  assign is_leaf      = out_rec.is_leaf;
  assign symbol       = out_rec.symbol;
  assign left_child   = out_rec.left_child;
  assign right_child  = out_rec.right_child;
  assign tree_done    = out_rec.tree_done;
  assign error_flag   = out_rec.error_flag;
  assign last_of_byte = out_rec.last_of_byte;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(MAX_LEAVES))
    else $error("stack depth beyond capacity");

  a_node_bound: assert property (@(posedge clk) disable iff (rst)
    next_node <= NODE_W'(MAX_NODES))
    else $error("node counter beyond node range");

  a_done_xor_fail: assert property (@(posedge clk) disable iff (rst)
    !(finished && failed))
    else $error("decoder both finished and failed");

  a_read_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ && pend_valid && out_valid && out_stall) |=>
      (state == S_READ && $stable(depth)))
    else $error("branch completed with no room for its record");

  a_branch_depth: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (depth >= DEPTH_W'(2)))
    else $error("branch read with fewer than two entries");

endmodule
